[design/two_half_reassembly_table_macros.svh]
// Assertion macros shared by the checker of the two-half reassembly table.
// Depends on nothing; the including module must provide clk and rst.
`ifndef TWO_HALF_REASSEMBLY_TABLE_MACROS_SVH
`define TWO_HALF_REASSEMBLY_TABLE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define THT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define THT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tht_pkg.sv]
// Package of the two-half reassembly table: item types, entry layout, constants.
// Depends on nothing; used by the top level, the checker and the testbench.
package tht_pkg;

  // Default table depth and register reset value.
  localparam int          ENTRY_COUNT_DEF = 16;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd8000;

  // Input mode codes.
  localparam logic MODE_HALF = 1'b0;
  localparam logic MODE_FULL = 1'b1;

  // One input item.
  typedef struct packed {
    logic        mode;
    logic [31:0] sensor_id;
    logic [31:0] seq_num;
    logic        from_path_b;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [31:0] now_ms;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] out_sensor_id;
    logic [31:0] out_seq_num;
    logic [31:0] out_first;
    logic [31:0] out_second;
    logic        first_valid;
    logic        second_valid;
  } out_item_t;

  // One table entry as held in the entry RAM.
  typedef struct packed {
    logic [31:0] sensor;
    logic [31:0] seq;
    logic [31:0] first;
    logic [31:0] second;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

[design/tht_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/two_half_reassembly_table.sv]
// Two-half reassembly table. A half item (mode 0) is looked up by sensor ID and
// sequence number with a sequential scan of the entry RAM, one entry per cycle
// through a single shared key comparator; a miss takes over the entry at a
// circular allocation pointer. A half item is accepted, then scanned through the
// registered RAM read port, then used to update the entry and, when it completes
// or times out, loaded into the result register. A hit on entry k ends the scan
// at that entry; a miss scans every entry. A full item (mode 1) goes straight
// to the result register and does not
// touch the table. The result register holds one finished item while the next
// item is accepted; a new result that finds it still occupied waits in the
// emit step until out_ready frees it, and the block is not ready meanwhile. No
// clearing pass is needed after reset: entry flags live in flip-flops.
// Depends on tht_pkg and tht_ram.
module two_half_reassembly_table
  import tht_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(ENTRY_COUNT);
  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);

  state_t              state, state_next;
  in_item_t            item;
  out_item_t           pend;
  entry_t              ent;
  logic [15:0]         timeout;
  logic [CNT_W-1:0]    rd_idx;
  logic                cmp_live;
  logic [IDX_W-1:0]    cmp_idx;
  logic                hit;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W-1:0]    alloc_ptr;
  logic [ENTRY_COUNT-1:0] entry_valid, has_first, has_second;

  logic        ram_we;
  logic [IDX_W-1:0] ram_raddr;
  entry_t      ram_wdata, ram_rdata;

  logic        in_acc, out_free, issue;
  logic        key_match, scan_miss;
  logic        old_hf, old_hs, new_hf, new_hs;
  entry_t      base;
  logic [31:0] age;
  logic        timed_out, do_emit;
  out_item_t   rec;

  // Entry storage: key, values and arrival stamp.
  tht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRY_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Handshake helpers.
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign issue    = rd_idx < CNT_W'(ENTRY_COUNT);

  // Shared key comparator on the entry read back from the RAM.
  assign key_match = cmp_live && entry_valid[cmp_idx] &&
                     (ram_rdata.sensor == item.sensor_id) &&
                     (ram_rdata.seq == item.seq_num);
  assign scan_miss = cmp_live && (cmp_idx == IDX_W'(ENTRY_COUNT - 1)) && !key_match;

  // Merge of the arriving half into the hit entry or into a fresh one.
  always_comb begin
    old_hf = hit && has_first[slot];
    old_hs = hit && has_second[slot];
    new_hf = old_hf || !item.from_path_b;
    new_hs = old_hs || item.from_path_b;
    if (hit) begin
      base = ent;
    end else begin
      base.sensor = item.sensor_id;
      base.seq    = item.seq_num;
      base.first  = item.first_value;
      base.second = item.first_value;
      base.stamp  = item.now_ms;
    end
    ram_wdata = base;
    if (item.from_path_b) begin
      ram_wdata.second = item.first_value;
    end else begin
      ram_wdata.first = item.first_value;
    end
    age       = item.now_ms - base.stamp;
    timed_out = age > {16'd0, timeout};
    do_emit   = (new_hf && new_hs) || timed_out;
    rec.out_sensor_id = item.sensor_id;
    rec.out_seq_num   = item.seq_num;
    rec.out_first     = new_hf ? ram_wdata.first : 32'd0;
    rec.out_second    = new_hs ? ram_wdata.second : 32'd0;
    rec.first_valid   = new_hf;
    rec.second_valid  = new_hs;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (in_item.mode == MODE_FULL) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (key_match || scan_miss) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = do_emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = rd_idx[IDX_W-1:0];
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   ram_raddr = rd_idx[IDX_W-1:0];
      ST_UPDATE: ram_we = 1'b1;
      ST_EMIT:   ram_we = 1'b0;
      default:   in_ready = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      timeout     <= TIMEOUT_RESET;
      alloc_ptr   <= '0;
      entry_valid <= '0;
      has_first   <= '0;
      has_second  <= '0;
      cmp_live    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (state == ST_IDLE) begin
        cmp_live <= 1'b0;
      end else if (state == ST_SCAN) begin
        cmp_live <= issue;
      end
      if (state == ST_SCAN && !key_match && scan_miss) begin
        alloc_ptr <= (alloc_ptr == IDX_W'(ENTRY_COUNT - 1)) ? '0 : alloc_ptr + 1'b1;
      end
      if (state == ST_UPDATE) begin
        entry_valid[slot] <= !do_emit;
        has_first[slot]   <= new_hf;
        has_second[slot]  <= new_hs;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rd_idx <= '0;
      if (in_acc) begin
        item <= in_item;
        pend.out_sensor_id <= in_item.sensor_id;
        pend.out_seq_num   <= in_item.seq_num;
        pend.out_first     <= in_item.first_value;
        pend.out_second    <= in_item.second_value;
        pend.first_valid   <= 1'b1;
        pend.second_valid  <= 1'b1;
      end
    end
    if (state == ST_SCAN) begin
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      cmp_idx <= rd_idx[IDX_W-1:0];
      if (key_match) begin
        hit  <= 1'b1;
        slot <= cmp_idx;
        ent  <= ram_rdata;
      end else if (scan_miss) begin
        hit  <= 1'b0;
        slot <= alloc_ptr;
      end
    end
    if (state == ST_UPDATE) begin
      pend <= rec;
    end
    if (state == ST_EMIT && out_free) begin
      out_item <= pend;
    end
  end

endmodule

[design/tht_checker.sv]
// Port-level checker of the two-half reassembly table, bound to the top level.
// Depends on tht_pkg and two_half_reassembly_table_macros.svh.
`include "two_half_reassembly_table_macros.svh"

module tht_checker
  import tht_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // A stalled result item holds its payload.
  `THT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result item changed while stalled")

  // The block works on one item at a time.
  `THT_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready stayed high after an accepted item")

  // Every result carries at least one half, and an absent first value reads as zero.
  `THT_ASSERT(a_some_half, out_valid |-> out_item.first_valid || out_item.second_valid, "result item without any half")
  `THT_ASSERT(a_zero_absent, out_valid && !out_item.first_valid |-> out_item.out_first == 32'd0, "absent first value is not zero")

  // Reset leaves no result pending.
  `THT_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result item valid after reset")

endmodule

bind two_half_reassembly_table tht_checker u_tht_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

[tb/tb_top.sv]
// Self-checking testbench for the two-half reassembly table: a directed table of
// items, then random phases under several timeout settings. Depends on tht_pkg
// and the two_half_reassembly_table top level.
module tb_top
  import tht_pkg::*;
();

  localparam int ITEM_CYCLES  = ENTRY_COUNT_DEF + 4;
  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 75;
  localparam int PHASE_COUNT  = 6;
  localparam logic PATH_A     = 1'b0;
  localparam logic PATH_B     = 1'b1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // One row of the directed table; rec is used only when typed is set.
  typedef struct {
    in_item_t  item;
    bit        typed;
    bit        emits;
    out_item_t rec;
  } stim_row_t;

  // Shadow copy of the reassembly table and its register.
  bit          tbl_valid  [ENTRY_COUNT_DEF];
  bit          tbl_has_a  [ENTRY_COUNT_DEF];
  bit          tbl_has_b  [ENTRY_COUNT_DEF];
  bit [31:0]   tbl_sid    [ENTRY_COUNT_DEF];
  bit [31:0]   tbl_seq    [ENTRY_COUNT_DEF];
  bit [31:0]   tbl_first  [ENTRY_COUNT_DEF];
  bit [31:0]   tbl_second [ENTRY_COUNT_DEF];
  bit [31:0]   tbl_stamp  [ENTRY_COUNT_DEF];
  int          next_slot   = 0;
  bit [15:0]   timeout_cfg = TIMEOUT_RESET;

  out_item_t   pending_records[$];
  stim_row_t   rows[$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          stall_left     = 0;
  bit          jitter_on      = 1'b1;
  logic [31:0] clock_ms       = '0;

  two_half_reassembly_table dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Idle length: mostly short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(99, 0) < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Applies one item to the shadow table; returns 1 when a record comes out.
  function automatic bit reassemble(input in_item_t it, output out_item_t rec);
    int        slot;
    int        k;
    bit        hit;
    bit [31:0] age;
    rec  = '0;
    slot = 0;
    hit  = 1'b0;
    if (it.mode == MODE_FULL) begin
      rec = '{it.sensor_id, it.seq_num, it.first_value, it.second_value, 1'b1, 1'b1};
      return 1'b1;
    end
    // Lowest matching entry wins.
    for (k = 0; k < ENTRY_COUNT_DEF && !hit; k++) begin
      if (tbl_valid[k] && tbl_sid[k] == it.sensor_id && tbl_seq[k] == it.seq_num) begin
        slot = k;
        hit  = 1'b1;
      end
    end
    // A miss takes over the entry at the allocation pointer.
    if (!hit) begin
      slot            = next_slot;
      next_slot       = (slot + 1) % ENTRY_COUNT_DEF;
      tbl_valid[slot] = 1'b1;
      tbl_sid[slot]   = it.sensor_id;
      tbl_seq[slot]   = it.seq_num;
      tbl_has_a[slot] = 1'b0;
      tbl_has_b[slot] = 1'b0;
      tbl_stamp[slot] = it.now_ms;
    end
    if (it.from_path_b == PATH_B) begin
      tbl_has_b[slot]  = 1'b1;
      tbl_second[slot] = it.first_value;
    end else begin
      tbl_has_a[slot]  = 1'b1;
      tbl_first[slot]  = it.first_value;
    end
    age = it.now_ms - tbl_stamp[slot];
    if ((tbl_has_a[slot] && tbl_has_b[slot]) || age > {16'd0, timeout_cfg}) begin
      rec = '{tbl_sid[slot], tbl_seq[slot],
              tbl_has_a[slot] ? tbl_first[slot] : 32'd0,
              tbl_has_b[slot] ? tbl_second[slot] : 32'd0,
              tbl_has_a[slot], tbl_has_b[slot]};
      tbl_valid[slot] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic in_item_t mk_half(input logic [31:0] sid, input logic [31:0] seq,
                                       input logic path, input logic [31:0] val,
                                       input logic [31:0] now);
    // The unused second value carries noise that the block must ignore.
    return '{MODE_HALF, sid, seq, path, val, ~val, now};
  endfunction

  function automatic out_item_t mk_rec(input logic [31:0] sid, input logic [31:0] seq,
                                       input logic [31:0] a, input logic [31:0] b,
                                       input logic va, input logic vb);
    return '{sid, seq, a, b, va, vb};
  endfunction

  // Random item: mostly the missing half of an open entry, else new keys,
  // repeated halves and full records.
  function automatic in_item_t make_random_item();
    in_item_t    it;
    int          open_slots[$];
    int          pick;
    int          r;
    int unsigned span;
    span = 32'(timeout_cfg);
    r    = $urandom_range(99, 0);
    if (r < 2) clock_ms = $urandom;
    else if (r < 15) clock_ms = clock_ms + $urandom_range(2 * span + 4, span / 2);
    else clock_ms = clock_ms + $urandom_range(span / 8 + 3, 0);
    it.mode         = MODE_HALF;
    it.now_ms       = clock_ms;
    it.first_value  = $urandom;
    it.second_value = $urandom;
    it.from_path_b  = 1'($urandom_range(1, 0));
    for (int k = 0; k < ENTRY_COUNT_DEF; k++) begin
      if (tbl_valid[k]) open_slots.push_back(k);
    end
    r = $urandom_range(99, 0);
    if (r >= 10 && r < 70 && open_slots.size() > 0) begin
      pick           = open_slots[$urandom_range(open_slots.size() - 1, 0)];
      it.sensor_id   = tbl_sid[pick];
      it.seq_num     = tbl_seq[pick];
      // Usually the missing half, sometimes the held half again.
      it.from_path_b = (r < 64) ? tbl_has_a[pick] : tbl_has_b[pick];
    end else begin
      pick = $urandom_range(9, 0);
      if (pick < 5) begin
        it.sensor_id = $urandom_range(3, 0);
        it.seq_num   = $urandom_range(3, 0);
      end else if (pick < 9) begin
        it.sensor_id = $urandom;
        it.seq_num   = $urandom;
      end else begin
        it.sensor_id = {32{1'($urandom_range(1, 0))}};
        it.seq_num   = {32{1'($urandom_range(1, 0))}};
      end
    end
    if (r < 10) it.mode = MODE_FULL;
    return it;
  endfunction

  // Sends one item, then records what it should produce.
  task automatic push_item(input in_item_t it, input bit typed, input bit emits,
                           input out_item_t typed_rec);
    int        gap;
    bit        made;
    out_item_t rec;
    gap = (jitter_on && $urandom_range(99, 0) >= 60) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    made = reassemble(it, rec);
    if (typed) begin
      if (emits) pending_records.push_back(typed_rec);
    end else if (made) begin
      pending_records.push_back(rec);
    end
  endtask

  // Stops sending and waits for the block to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 8) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    timeout_cfg = value;
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s: got %h, want %h", what, got, want);
  endtask

  // Receiver: random stalls while jitter is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (jitter_on && $urandom_range(99, 0) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Compare each accepted record with the oldest expected one.
  always @(posedge clk) begin : check_records
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_records.size() == 0) begin
        report("unexpected record, sensor_id", out_item.out_sensor_id, '0);
      end else begin
        want = pending_records.pop_front();
        if (out_item.out_sensor_id !== want.out_sensor_id)
          report("out_sensor_id", out_item.out_sensor_id, want.out_sensor_id);
        if (out_item.out_seq_num !== want.out_seq_num)
          report("out_seq_num", out_item.out_seq_num, want.out_seq_num);
        if (out_item.out_first !== want.out_first)
          report("out_first", out_item.out_first, want.out_first);
        if (out_item.out_second !== want.out_second)
          report("out_second", out_item.out_second, want.out_second);
        if (out_item.first_valid !== want.first_valid)
          report("first_valid", 32'(out_item.first_valid), 32'(want.first_valid));
        if (out_item.second_valid !== want.second_valid)
          report("second_valid", 32'(out_item.second_valid), 32'(want.second_valid));
      end
    end
  end

  // Watchdog: too long without any item moving ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] setting;
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;

    // Directed items, run with the timeout at its reset value.
    rows.push_back('{'{MODE_FULL, 32'd0, 32'd0, PATH_A, 32'd0, 32'd0, 32'd0},
                     1'b1, 1'b1, mk_rec(32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1)});
    rows.push_back('{'{MODE_FULL, '1, '1, PATH_B, '1, '1, '1},
                     1'b1, 1'b1, mk_rec('1, '1, '1, '1, 1'b1, 1'b1)});
    // Plain pair of halves.
    rows.push_back('{mk_half(32'd1, 32'd1, PATH_A, 32'hA5A5_A5A5, 32'd100), 1'b1, 1'b0, '0});
    rows.push_back('{mk_half(32'd1, 32'd1, PATH_B, 32'h5A5A_5A5A, 32'd200), 1'b1, 1'b1,
                     mk_rec(32'd1, 32'd1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 1'b1)});
    // Second half first, sent twice: the newer value wins.
    rows.push_back('{mk_half(32'd2, 32'd7, PATH_B, 32'h22, 32'd300), 1'b1, 1'b0, '0});
    rows.push_back('{mk_half(32'd2, 32'd7, PATH_B, 32'h33, 32'd305), 1'b1, 1'b0, '0});
    rows.push_back('{mk_half(32'd2, 32'd7, PATH_A, 32'h11, 32'd310), 1'b1, 1'b1,
                     mk_rec(32'd2, 32'd7, 32'h11, 32'h33, 1'b1, 1'b1)});
    // Age equal to the timeout holds; one more millisecond emits a partial record.
    rows.push_back('{mk_half(32'd3, 32'd3, PATH_A, 32'd5, 32'd1000), 1'b1, 1'b0, '0});
    rows.push_back('{mk_half(32'd4, 32'd4, PATH_B, 32'h44, 32'd1000), 1'b1, 1'b0, '0});
    rows.push_back('{mk_half(32'd3, 32'd3, PATH_A, 32'd6, 32'd9000), 1'b1, 1'b0, '0});
    rows.push_back('{mk_half(32'd3, 32'd3, PATH_A, 32'd7, 32'd9001), 1'b1, 1'b1,
                     mk_rec(32'd3, 32'd3, 32'd7, 32'd0, 1'b1, 1'b0)});
    rows.push_back('{mk_half(32'd4, 32'd4, PATH_B, 32'h45, 32'd9001), 1'b1, 1'b1,
                     mk_rec(32'd4, 32'd4, 32'd0, 32'h45, 1'b0, 1'b1)});
    // Clock wrap, with a full record on the same key in between.
    rows.push_back('{mk_half(32'd5, 32'd5, PATH_A, 32'h55, 32'hFFFF_FF00), 1'b1, 1'b0, '0});
    rows.push_back('{'{MODE_FULL, 32'd5, 32'd5, PATH_A, 32'hAAAA_0000, 32'h0000_AAAA, 32'h80},
                     1'b1, 1'b1, mk_rec(32'd5, 32'd5, 32'hAAAA_0000, 32'h0000_AAAA,
                                        1'b1, 1'b1)});
    rows.push_back('{mk_half(32'd5, 32'd5, PATH_A, 32'h56, 32'h100), 1'b0, 1'b0, '0});
    rows.push_back('{mk_half(32'd5, 32'd5, PATH_B, 32'h57, 32'h200), 1'b0, 1'b0, '0});
    // All-ones key, with an all-ones and a zero value.
    rows.push_back('{mk_half('1, '1, PATH_B, '1, 32'h200), 1'b0, 1'b0, '0});
    rows.push_back('{mk_half('1, '1, PATH_A, 32'd0, 32'h300), 1'b1, 1'b1,
                     mk_rec('1, '1, 32'd0, '1, 1'b1, 1'b1)});
    // Largest possible age.
    rows.push_back('{mk_half(32'd0, 32'd0, PATH_A, 32'd0, 32'd0), 1'b0, 1'b0, '0});
    rows.push_back('{mk_half(32'd0, 32'd0, PATH_A, 32'd1, '1), 1'b1, 1'b1,
                     mk_rec(32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b0)});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) push_item(rows[i].item, rows[i].typed, rows[i].emits, rows[i].rec);

    // Random phases, each under its own timeout; one phase runs without idling.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      case (ph)
        0:       setting = 16'd0;
        1:       setting = 16'hFFFF;
        2:       setting = 16'd1;
        3:       setting = 16'($urandom_range(65535, 2));
        4:       setting = TIMEOUT_RESET;
        default: setting = 16'($urandom_range(200, 2));
      endcase
      set_timeout(setting);
      jitter_on = (ph != 3);
      repeat (PHASE_ITEMS) push_item(make_random_item(), 1'b0, 1'b0, '0);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tht_pkg.sv
design/tht_ram.sv
design/two_half_reassembly_table.sv
design/tht_checker.sv
tb/tb_top.sv
